[sv/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

  localparam int unsigned CDQ_DEPTH = 16;
  localparam int unsigned DATA_W    = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       pop;
  } oq_status_t;

endpackage

`default_nettype wire

[sv/cdq_ram.sv]
`default_nettype none

module cdq_ram #(
  parameter int unsigned DEPTH = cdq_pkg::CDQ_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [AW-1:0]                      waddr_i,
  input  wire logic signed [cdq_pkg::DATA_W-1:0]  wdata_i,
  input  wire logic                               re_i,
  input  wire logic [AW-1:0]                      raddr_i,
  output logic signed [cdq_pkg::DATA_W-1:0]       rdata_o
);
  import cdq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/cdq_outq.sv]
`default_nettype none

module cdq_outq (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  input  wire cdq_pkg::result_t                   push_res_i,
  output cdq_pkg::oq_status_t                     stat_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              status_o,
  output logic signed [cdq_pkg::DATA_W-1:0]       data_o,
  output logic                                    last_o
);
  import cdq_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_res_i;
    end
  end

  assign status_o = slot_q[rd_ptr_q].status;
  assign data_o   = slot_q[rd_ptr_q].data;
  assign last_o   = slot_q[rd_ptr_q].last;

  assign stat_o.cnt = cnt_q;
  assign stat_o.pop = pop;

endmodule

`default_nettype wire

[sv/circular_deque.sv]
`default_nettype none
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------
// input    | in_valid_i   | in_stall_o   | action_i, value_i
// output   | out_valid_o  | out_stall_i  | status_o, data_o, last_o
//
// push and error items go straight into the result queue; pops first wait on a ram read
// a list of n words issues n ram reads, one per cycle while the result queue has room, input held meanwhile
// the ram read is registered and the result queue holds two entries
// reset clears pointers, count and queue; ram contents stay undefined
// output stalls back up into the input once the result queue is full

module circular_deque #(
  parameter int unsigned DEPTH = cdq_pkg::CDQ_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [2:0]                         action_i,
  input  wire logic signed [cdq_pkg::DATA_W-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              status_o,
  output logic signed [cdq_pkg::DATA_W-1:0]       data_o,
  output logic                                    last_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  state_e      state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          rd_pend_q, rd_pend_d;
  logic          rd_last_q, rd_last_d;

  logic [AW-1:0] head_next, head_prev, tail_next, tail_prev, ptr_next;
  logic          full, empty, space_ok, accept;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic signed [DATA_W-1:0] rdata;

  logic          push;
  result_t       push_res;
  oq_status_t    oq_stat;

  assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_prev = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - 1'b1;
  assign ptr_next  = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;

  assign full  = (cnt_q == FullCnt);
  assign empty = (cnt_q == '0);

  // a result issued now still fits in the queue when it lands
  assign space_ok = ({1'b0, oq_stat.cnt} + {2'b00, rd_pend_q})
                  < (3'd2 + {2'b00, oq_stat.pop});

  assign in_stall_o = !((state_q == S_IDLE) && !rd_pend_q && space_ok);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    rd_pend_d = 1'b0;
    rd_last_d = rd_last_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = head_q;
    raddr     = head_q;
    push      = rd_pend_q;
    push_res  = '{status: STAT_DONE, data: rdata, last: rd_last_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              push = 1'b1;
              if (full) begin
                push_res = '{status: STAT_FULL, data: '0, last: 1'b1};
              end else begin
                we       = 1'b1;
                cnt_d    = cnt_q + 1'b1;
                push_res = '{status: STAT_DONE, data: value_i, last: 1'b1};
                if (action_i == ACT_PUSH_FRONT) begin
                  waddr  = head_prev;
                  head_d = head_prev;
                end else begin
                  waddr  = tail_q;
                  tail_d = tail_next;
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
              if (empty) begin
                push     = 1'b1;
                push_res = '{status: STAT_EMPTY, data: '0, last: 1'b1};
              end else begin
                re        = 1'b1;
                cnt_d     = cnt_q - 1'b1;
                rd_pend_d = 1'b1;
                rd_last_d = 1'b1;
                if (action_i == ACT_POP_FRONT) begin
                  raddr  = head_q;
                  head_d = head_next;
                end else begin
                  raddr  = tail_prev;
                  tail_d = tail_prev;
                end
              end
            end
            ACT_LIST: begin
              if (empty) begin
                push     = 1'b1;
                push_res = '{status: STAT_EMPTY, data: '0, last: 1'b1};
              end else begin
                re        = 1'b1;
                raddr     = head_q;
                ptr_d     = head_next;
                rem_d     = cnt_q - 1'b1;
                rd_pend_d = 1'b1;
                rd_last_d = (cnt_q == CW'(1));
                if (cnt_q != CW'(1)) begin
                  state_d = S_LIST;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (space_ok) begin
          re        = 1'b1;
          raddr     = ptr_q;
          ptr_d     = ptr_next;
          rem_d     = rem_q - 1'b1;
          rd_pend_d = 1'b1;
          rd_last_d = (rem_q == CW'(1));
          if (rem_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end else begin
          rd_last_d = rd_last_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      rd_pend_q <= rd_pend_d;
      rd_last_q <= rd_last_d;
    end
  end

  cdq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cdq_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_res_i  (push_res),
    .stat_o      (oq_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

[tb/circular_deque_test.sv]
`timescale 1ns / 1ps

module circular_deque_test;
  import cdq_pkg::*;

  localparam int IDX_W        = $clog2(CDQ_DEPTH);
  localparam int RANDOM_ITEMS = 190;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;

  // action codes the block must ignore
  localparam logic [2:0] ACT_RSVD_5 = 3'd5;
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [2:0]        act;
    logic [DATA_W-1:0] val;
    logic [5:0]        reps;
    logic              known;
    result_t           res;
  } row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [2:0]               action_i    = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] data_o;
  logic                     last_o;

  // shadow copy of the deque
  logic [DATA_W-1:0] shadow_ring [CDQ_DEPTH];
  logic [IDX_W-1:0]  shadow_head  = '0;
  logic [IDX_W-1:0]  shadow_tail  = '0;
  logic [IDX_W:0]    shadow_count = '0;

  result_t step_results[$];
  result_t pending_results[$];
  row_t    directed_rows[$];

  bit tx_quiet    = 1'b0;
  int mismatches  = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_lists     = 0;
  int n_full      = 0;
  int n_empty     = 0;
  int peak_count  = 0;

  circular_deque u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic result_t mk_result(status_e st, logic [DATA_W-1:0] d, logic l);
    result_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    return r;
  endfunction

  task automatic deque_step(input logic [2:0] act, input logic [DATA_W-1:0] val);
    logic [IDX_W-1:0]  p;
    logic [DATA_W-1:0] word;
    step_results.delete();
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (shadow_count == CDQ_DEPTH) begin
          n_full++;
          step_results.push_back(mk_result(STAT_FULL, '0, 1'b1));
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            shadow_head = shadow_head - 1'b1;
            shadow_ring[shadow_head] = val;
          end else begin
            shadow_ring[shadow_tail] = val;
            shadow_tail = shadow_tail + 1'b1;
          end
          shadow_count++;
          step_results.push_back(mk_result(STAT_DONE, val, 1'b1));
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (shadow_count == 0) begin
          n_empty++;
          step_results.push_back(mk_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          if (act == ACT_POP_FRONT) begin
            word = shadow_ring[shadow_head];
            shadow_head = shadow_head + 1'b1;
          end else begin
            shadow_tail = shadow_tail - 1'b1;
            word = shadow_ring[shadow_tail];
          end
          shadow_count--;
          step_results.push_back(mk_result(STAT_DONE, word, 1'b1));
        end
      end
      ACT_LIST: begin
        if (shadow_count == 0) begin
          n_empty++;
          step_results.push_back(mk_result(STAT_EMPTY, '0, 1'b1));
        end else begin
          n_lists++;
          p = shadow_head;
          for (int n = 0; n < shadow_count; n++) begin
            step_results.push_back(mk_result(STAT_DONE, shadow_ring[p],
                                             n == shadow_count - 1));
            p = p + 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [2:0] act, input logic [DATA_W-1:0] val,
                           input bit known, input result_t known_res);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_items++;
    deque_step(act, val);
    if (shadow_count > peak_count) peak_count = shadow_count;
    if (known) pending_results.push_back(known_res);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  task automatic add_row(input logic [2:0] act, input logic [DATA_W-1:0] val,
                         input int reps, input bit known, input status_e st,
                         input logic [DATA_W-1:0] d);
    row_t row;
    row.act   = act;
    row.val   = val;
    row.reps  = 6'(reps);
    row.known = known;
    row.res   = mk_result(st, d, 1'b1);
    directed_rows.push_back(row);
  endtask

  initial begin : stimulus
    row_t              row;
    logic [2:0]        act;
    logic [DATA_W-1:0] val;
    int                pick;
    bit                filling;
    bit                push;
    int                sent;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque, ignored codes, extremes, fill across the wrap, full, list, pop at both ends
    add_row(ACT_POP_FRONT,  32'h0000_0000, 1,  1, STAT_EMPTY, '0);
    add_row(ACT_POP_REAR,   32'hFFFF_FFFF, 1,  1, STAT_EMPTY, '0);
    add_row(ACT_LIST,       32'h0000_0000, 1,  1, STAT_EMPTY, '0);
    add_row(ACT_RSVD_5,     32'h1234_5678, 1,  0, STAT_DONE,  '0);
    add_row(ACT_RSVD_6,     32'hFFFF_FFFF, 1,  0, STAT_DONE,  '0);
    add_row(ACT_RSVD_7,     32'h0000_0000, 1,  0, STAT_DONE,  '0);
    add_row(ACT_PUSH_FRONT, 32'h8000_0000, 1,  1, STAT_DONE,  32'h8000_0000);
    add_row(ACT_PUSH_REAR,  32'h7FFF_FFFF, 1,  1, STAT_DONE,  32'h7FFF_FFFF);
    add_row(ACT_PUSH_REAR,  32'h0000_0000, 14, 0, STAT_DONE,  '0);
    add_row(ACT_PUSH_FRONT, 32'h0000_0000, 1,  1, STAT_FULL,  '0);
    add_row(ACT_PUSH_REAR,  32'hFFFF_FFFF, 1,  1, STAT_FULL,  '0);
    add_row(ACT_LIST,       32'h0000_0000, 1,  0, STAT_DONE,  '0);
    add_row(ACT_POP_FRONT,  32'h0000_0000, 1,  0, STAT_DONE,  '0);
    add_row(ACT_POP_REAR,   32'h0000_0000, 1,  0, STAT_DONE,  '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        val = (row.reps > 1) ? $urandom() : row.val;
        send_item(row.act, val, row.known, row.res);
      end
    end

    // random part swings between filling and draining so both ends get hit
    filling = 1'b1;
    sent    = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 24 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
      if (shadow_count == CDQ_DEPTH && $urandom_range(0, 2) != 0) filling = 1'b0;
      else if (shadow_count == 0 && $urandom_range(0, 2) != 0) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        act = 3'($urandom_range(ACT_RSVD_5, ACT_RSVD_7));
      end else if (pick < 12) begin
        act = ACT_LIST;
      end else begin
        push = filling ? ($urandom_range(0, 99) < 75) : ($urandom_range(0, 99) < 25);
        if (push) act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        else act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
      end
      case ($urandom_range(0, 9))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = '0;
        3: val = '1;
        default: val = $urandom();
      endcase
      send_item(act, val, 1'b0, '0);
      if (act <= ACT_LIST) sent++;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d input transfers, %0d results, %0d non-empty lists, peak fill %0d",
             n_items, n_results, n_lists, peak_count);
    $display("rejections seen: %0d push into full, %0d pop or list on empty",
             n_full, n_empty);
    if (mismatches == 0) begin
      $display("circular_deque: match");
    end else begin
      $display("circular_deque: mismatch");
    end
    $finish;
  end

  initial begin : receiver
    int waits;
    int xfers;
    bit rx_quiet;
    xfers    = 0;
    rx_quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (xfers % 32 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      // long hold-off lets the result queue fill and back up into the input
      if (xfers == 40 || xfers == 300) waits = HOLD_CYCLES;
      else waits = rx_quiet ? 0 : $urandom_range(0, 8);
      if (waits > 0) begin
        out_stall_i <= 1'b1;
        repeat (waits) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      xfers++;
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("unexpected result: status %0d data %h last %0d", status_o, data_o, last_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          mismatches++;
          $error("status: expected %0d, got %0d", want.status, status_o);
        end
        if (data_o !== want.data) begin
          mismatches++;
          $error("data: expected %h, got %h", want.data, data_o);
        end
        if (last_o !== want.last) begin
          mismatches++;
          $error("last: expected %0d, got %0d", want.last, last_o);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("circular_deque: mismatch");
    $finish;
  end

endmodule

[files.f]
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_outq.sv
sv/circular_deque.sv
tb/circular_deque_test.sv
